[src/kssp_pkg.sv]
package kssp_pkg;

  // Pool geometry. STACKS is a power of two: the stack id is masked to its low bits.
  localparam int CAPACITY = 64;
  localparam int STACKS   = 8;

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int LINK_W  = $clog2(CAPACITY + 1);
  localparam int SID_W   = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int DATA_W  = 32;
  localparam int ID_W    = 3;
  localparam int COUNT_W = 7;

  // A link equal to CAPACITY (or above) is the null link.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                     opcode;
    logic [ID_W-1:0]          stack_id;
    logic signed [DATA_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic                     stack_empty;
    logic                     pool_full;
    logic [COUNT_W-1:0]       stack_count;
  } out_rsp_t;

  // Write request into the slot store: the link is always written, the value on push only.
  typedef struct packed {
    logic              en;
    logic              val_en;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] next;
    logic [DATA_W-1:0] value;
  } slot_wr_t;

endpackage

[src/kssp_slot_mem.sv]
module kssp_slot_mem
  import kssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_next,
  output logic [DATA_W-1:0] rd_value,
  input  slot_wr_t          wr
);

  logic [LINK_W-1:0] next_mem  [CAPACITY];
  logic [DATA_W-1:0] value_mem [CAPACITY];

  // linked_r marks entries whose link was written; others read as their reset link i+1
  logic [CAPACITY-1:0] linked_r;
  logic                rd_linked_r;
  logic [SLOT_W-1:0]   rd_addr_r;
  logic [LINK_W-1:0]   next_q_r;
  logic [DATA_W-1:0]   value_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      next_mem[wr.addr] <= wr.next;
    end
    if (wr.en && wr.val_en) begin
      value_mem[wr.addr] <= wr.value;
    end
    if (rd_en) begin
      next_q_r  <= next_mem[rd_addr];
      value_q_r <= value_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linked_r    <= '0;
      rd_linked_r <= 1'b0;
    end else begin
      if (wr.en) begin
        linked_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_linked_r <= linked_r[rd_addr];
      end
    end
  end

  assign rd_next  = rd_linked_r ? next_q_r : (LINK_W'(rd_addr_r) + LINK_W'(1));
  assign rd_value = value_q_r;

endmodule

[src/k_stacks_shared_pool.sv]
// Flow: the accept cycle reads the slot store (synchronous read of link and value);
//   in the update cycle that follows, the block updates heads, writes the slot back and
//   registers the result, which is then strobed on out_valid. busy is high during the
//   update cycle only, and no new request is accepted while busy is high.
// Reset (synchronous, rst_n low): all stacks empty, free list 0,1,...,CAPACITY-1; no sweep.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module k_stacks_shared_pool
  import kssp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  // Heads and counts live in flops; slot links and values live in the slot store.
  logic              busy_r;
  logic              out_valid_r;
  out_rsp_t          out_rsp_r;
  logic [LINK_W-1:0] free_top_r;
  logic [LINK_W-1:0] stack_top_r  [STACKS];
  logic [LINK_W-1:0] stack_size_r [STACKS];

  // Request held for the update cycle.
  logic              op_r;
  logic [SID_W-1:0]  sid_r;
  logic [DATA_W-1:0] val_r;
  logic [LINK_W-1:0] slot_r;

  logic              accept;
  logic [SID_W-1:0]  acc_sid;
  logic [LINK_W-1:0] acc_slot;
  logic [LINK_W-1:0] rd_next;
  logic [DATA_W-1:0] rd_value;
  slot_wr_t          wr;

  logic              slot_null;
  logic [LINK_W-1:0] cur_top;
  logic [LINK_W-1:0] cur_size;
  logic [LINK_W-1:0] free_nxt;
  logic [LINK_W-1:0] top_nxt;
  logic [LINK_W-1:0] size_nxt;
  out_rsp_t          rsp_nxt;

  assign accept  = start && !busy_r;
  assign acc_sid = in_req.stack_id[SID_W-1:0];
  // Push works on the free-list head, pop on the addressed stack's top.
  assign acc_slot = (in_req.opcode == OP_PUSH) ? free_top_r : stack_top_r[acc_sid];

  kssp_slot_mem u_slot_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (acc_slot[SLOT_W-1:0]),
    .rd_next  (rd_next),
    .rd_value (rd_value),
    .wr       (wr)
  );

  // Update cycle. Writes land at the edge that ends it, and no request is accepted during it,
  // so the next request's read already sees them: no forwarding path needed.
  always_comb begin
    slot_null = (slot_r >= NULL_LINK);
    cur_top   = stack_top_r[sid_r];
    cur_size  = stack_size_r[sid_r];
    free_nxt  = free_top_r;
    top_nxt   = cur_top;
    size_nxt  = cur_size;
    wr        = '0;
    rsp_nxt   = '0;
    rsp_nxt.status = ST_OK;
    if (op_r == OP_PUSH) begin
      if (slot_null) begin
        rsp_nxt.status = ST_FULL;
      end else begin
        wr.en     = busy_r;
        wr.val_en = 1'b1;
        wr.addr   = slot_r[SLOT_W-1:0];
        wr.next   = cur_top;
        wr.value  = val_r;
        free_nxt  = rd_next;
        top_nxt   = slot_r;
        size_nxt  = cur_size + LINK_W'(1);
      end
    end else begin
      if (slot_null) begin
        rsp_nxt.status    = ST_EMPTY;
        rsp_nxt.pop_value = '1;
      end else begin
        rsp_nxt.pop_value = rd_value;
        wr.en     = busy_r;
        wr.val_en = 1'b0;
        wr.addr   = slot_r[SLOT_W-1:0];
        wr.next   = free_top_r;
        free_nxt  = slot_r;
        top_nxt   = rd_next;
        size_nxt  = (cur_size != '0) ? (cur_size - LINK_W'(1)) : cur_size;
      end
    end
    rsp_nxt.stack_empty = (top_nxt >= NULL_LINK);
    rsp_nxt.pool_full   = (free_nxt >= NULL_LINK);
    rsp_nxt.stack_count = COUNT_W'(size_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      free_top_r  <= '0;
      for (int i = 0; i < STACKS; i++) begin
        stack_top_r[i]  <= NULL_LINK;
        stack_size_r[i] <= '0;
      end
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        free_top_r            <= free_nxt;
        stack_top_r[sid_r]    <= top_nxt;
        stack_size_r[sid_r]   <= size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req.opcode;
      sid_r  <= acc_sid;
      val_r  <= in_req.push_value;
      slot_r <= acc_slot;
    end
    if (busy_r) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted request did not enter update cycle");

  a_update_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (!busy_r && out_valid_r))
    else $error("update cycle did not end in a result strobe");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == ST_FULL) |-> out_rsp_r.pool_full)
    else $error("pool-full error without pool_full flag");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == ST_EMPTY) |->
      (out_rsp_r.stack_empty && out_rsp_r.stack_count == '0))
    else $error("empty-stack error with nonempty stack");

endmodule

[tb/tb_top.sv]
module tb_top;
  import kssp_pkg::*;

  // Cycles with neither a request nor a result accepted before giving up.
  // A correct run never goes past the longest sender gap plus the block's latency.
  localparam int STALL_LIMIT  = 300;
  localparam int RAND_REQS    = 1550;
  localparam int CALM_TAIL_AT = 1350;   // no sender idling in phases that start after this many random requests
  localparam int REPORT_MAX   = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  in_req_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  out_rsp_t out_rsp;

  k_stacks_shared_pool uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool predictor: its own copy of the slot store, the stack heads and the
  // free list. Heads and links at CAPACITY or above mean "null".
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] data_of [CAPACITY];
  logic [LINK_W-1:0]        link_of [CAPACITY];
  logic [LINK_W-1:0]        head_of [STACKS];
  int                       depth_of [STACKS];
  logic [LINK_W-1:0]        free_head;

  // Applies one request to the predicted pool and returns the result it must give.
  function automatic out_rsp_t pool_apply(in_req_t r);
    out_rsp_t o;
    int       s;
    int       slot;
    o = '0;
    s = int'(r.stack_id) % STACKS;
    if (r.opcode == OP_PUSH) begin
      slot = int'(free_head);
      if (slot >= CAPACITY) begin
        o.status = ST_FULL;            // pool exhausted: nothing moves
      end else begin
        free_head     = link_of[slot];
        link_of[slot] = head_of[s];
        head_of[s]    = LINK_W'(slot);
        data_of[slot] = r.push_value;
        depth_of[s]++;
      end
    end else begin
      slot = int'(head_of[s]);
      if (slot >= CAPACITY) begin
        o.status    = ST_EMPTY;        // empty stack: nothing moves, value reads -1
        o.pop_value = -1;
      end else begin
        o.pop_value   = data_of[slot];
        head_of[s]    = link_of[slot];
        link_of[slot] = free_head;     // freed slot goes back on top of the free list
        free_head     = LINK_W'(slot);
        if (depth_of[s] > 0) depth_of[s]--;
      end
    end
    o.stack_empty = (int'(head_of[s]) >= CAPACITY);
    o.pool_full   = (int'(free_head) >= CAPACITY);
    o.stack_count = COUNT_W'(depth_of[s]);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Expectations are queued at request acceptance, in order.
  // ---------------------------------------------------------------------------
  out_rsp_t rsp_due [$];
  int       fail_cnt = 0;
  int       stall_cycles = 0;

  // Hand-written expectation riding along with the current request (directed rows).
  logic     typed_on = 1'b0;
  out_rsp_t typed_want = '0;

  task automatic note_fail(string what, out_rsp_t want, out_rsp_t got);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX)
      $display({"%0t %s: exp val=%h st=%0d emp=%b full=%b cnt=%0d",
                " | got val=%h st=%0d emp=%b full=%b cnt=%0d"},
               $time, what,
               want.pop_value, want.status, want.stack_empty, want.pool_full, want.stack_count,
               got.pop_value, got.status, got.stack_empty, got.pool_full, got.stack_count);
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin : watch
    out_rsp_t want;
    out_rsp_t got;
    logic     moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid) begin
        moved = 1'b1;
        got   = out_rsp;
        if (rsp_due.size() == 0) begin
          note_fail("result with no request pending", '0, got);
        end else begin
          want = rsp_due.pop_front();
          if (got.pop_value !== want.pop_value || got.status !== want.status ||
              got.stack_empty !== want.stack_empty || got.pool_full !== want.pool_full ||
              got.stack_count !== want.stack_count)
            note_fail("result mismatch", want, got);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        // predictor always advances; directed rows may override what is expected
        want = pool_apply(in_req);
        rsp_due.push_back(typed_on ? typed_want : want);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. A row with reps > 1 repeats the request with random values.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic                     op;
    logic [ID_W-1:0]          sid;
    logic signed [DATA_W-1:0] val;
    int                       reps;
    logic                     typed;
    out_rsp_t                 want;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  plan_row_t plan [PLAN_ROWS] = '{
    // fresh pool: pops on empty stacks fail with -1
    '{OP_POP,  3'd0, 32'sd0,           1, 1'b1, '{-32'sd1, ST_EMPTY, 1'b1, 1'b0, 7'd0}},
    '{OP_POP,  3'd7, 32'sd0,           1, 1'b1, '{-32'sd1, ST_EMPTY, 1'b1, 1'b0, 7'd0}},
    // extreme values in and back out in LIFO order
    '{OP_PUSH, 3'd0, 32'sh7fffffff,    1, 1'b1, '{32'sd0, ST_OK, 1'b0, 1'b0, 7'd1}},
    '{OP_PUSH, 3'd0, 32'sh80000000,    1, 1'b1, '{32'sd0, ST_OK, 1'b0, 1'b0, 7'd2}},
    '{OP_POP,  3'd0, 32'sd0,           1, 1'b1, '{32'sh80000000, ST_OK, 1'b0, 1'b0, 7'd1}},
    '{OP_POP,  3'd0, 32'sd0,           1, 1'b1, '{32'sh7fffffff, ST_OK, 1'b1, 1'b0, 7'd0}},
    '{OP_POP,  3'd0, 32'sd0,           1, 1'b1, '{-32'sd1, ST_EMPTY, 1'b1, 1'b0, 7'd0}},
    '{OP_PUSH, 3'd7, 32'sd0,           1, 1'b1, '{32'sd0, ST_OK, 1'b0, 1'b0, 7'd1}},
    '{OP_PUSH, 3'd7, -32'sd1,          1, 1'b1, '{32'sd0, ST_OK, 1'b0, 1'b0, 7'd2}},
    '{OP_PUSH, 3'd3, 32'sh5a5a5a5a,    1, 1'b0, '0},
    '{OP_PUSH, 3'd1, 32'sha5a5a5a5,    1, 1'b0, '0},
    // a stored -1 comes back with status ok, unlike a failed pop
    '{OP_POP,  3'd7, 32'sd0,           1, 1'b1, '{-32'sd1, ST_OK, 1'b0, 1'b0, 7'd1}},
    '{OP_POP,  3'd3, 32'sd0,           1, 1'b0, '0},
    // fill to one slot short of capacity, then take the last slot
    '{OP_PUSH, 3'd5, 32'sd0,          61, 1'b0, '0},
    '{OP_PUSH, 3'd2, 32'sh00001234,    1, 1'b1, '{32'sd0, ST_OK, 1'b0, 1'b1, 7'd1}},
    // full pool: push refused, on a loaded and on an empty stack
    '{OP_PUSH, 3'd2, 32'sh0badf00d,    1, 1'b1, '{32'sd0, ST_FULL, 1'b0, 1'b1, 7'd1}},
    '{OP_PUSH, 3'd6, 32'sh0badf00d,    1, 1'b1, '{32'sd0, ST_FULL, 1'b1, 1'b1, 7'd0}},
    '{OP_POP,  3'd6, 32'sd0,           1, 1'b1, '{-32'sd1, ST_EMPTY, 1'b1, 1'b1, 7'd0}},
    '{OP_POP,  3'd2, 32'sd0,           1, 1'b1, '{32'sh00001234, ST_OK, 1'b1, 1'b0, 7'd0}},
    '{OP_PUSH, 3'd4, 32'sh7fffffff,    1, 1'b0, '0},
    // drain everything back out
    '{OP_POP,  3'd5, 32'sd0,          61, 1'b0, '0},
    '{OP_POP,  3'd1, 32'sd0,           1, 1'b1, '{32'sha5a5a5a5, ST_OK, 1'b1, 1'b0, 7'd0}},
    '{OP_POP,  3'd7, 32'sd0,           1, 1'b1, '{32'sd0, ST_OK, 1'b1, 1'b0, 7'd0}},
    '{OP_POP,  3'd4, 32'sd0,           1, 1'b1, '{32'sh7fffffff, ST_OK, 1'b1, 1'b0, 7'd0}}
  };

  logic signed [DATA_W-1:0] corner_vals [4] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};

  // Presents a request and returns at the edge that accepts it. start stays high,
  // so a back-to-back caller never drops it in between.
  task automatic issue(in_req_t r, logic with_typed, out_rsp_t want);
    in_req     <= r;
    typed_on   <= with_typed;
    typed_want <= want;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic rest(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin : drive
    in_req_t r;
    int      sent;
    int      span;
    int      mode;
    int      push_pct;
    int      idle_pct;
    int      sid;
    int      fa;
    int      fb;
    int      k;
    int      j;
    logic    drained_once;

    // predictor reset state: free list 0,1,...,CAPACITY-1, all stacks empty
    for (k = 0; k < CAPACITY; k++) begin
      data_of[k] = '0;
      link_of[k] = LINK_W'(k + 1);
    end
    link_of[CAPACITY-1] = NULL_LINK;
    for (k = 0; k < STACKS; k++) begin
      head_of[k]  = NULL_LINK;
      depth_of[k] = 0;
    end
    free_head = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (plan[i]) begin
      for (j = 0; j < plan[i].reps; j++) begin
        r.opcode     = plan[i].op;
        r.stack_id   = plan[i].sid;
        r.push_value = (plan[i].reps > 1) ? $urandom : plan[i].val;
        issue(r, plan[i].typed, plan[i].want);
        if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 6));
      end
    end

    // random part: phases that fill, drain or churn the pool, some of them
    // focused on two stacks so that deep stacks and full pools come up often
    sent = 0;
    drained_once = 1'b0;
    while (sent < RAND_REQS) begin
      span = $urandom_range(20, 120);
      mode = $urandom_range(0, 3);
      fa   = $urandom_range(0, STACKS - 1);
      fb   = $urandom_range(0, STACKS - 1);
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      idle_pct = (sent >= CALM_TAIL_AT || $urandom_range(0, 2) == 0) ? 0 : 30;
      for (k = 0; k < span && sent < RAND_REQS; k++) begin
        r.opcode = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        sid = (mode == 3) ? ($urandom_range(0, 1) ? fa : fb) : $urandom_range(0, STACKS - 1);
        // drain phases mostly aim at a loaded stack so pops succeed
        if (r.opcode == OP_POP && mode == 1 && $urandom_range(0, 4) != 0)
          for (j = 0; j < STACKS; j++)
            if (depth_of[(sid + j) % STACKS] > 0) begin
              sid = (sid + j) % STACKS;
              break;
            end
        r.stack_id   = ID_W'(sid);
        r.push_value = ($urandom_range(0, 7) == 0) ? corner_vals[$urandom_range(0, 3)]
                                                   : $urandom;
        issue(r, 1'b0, '0);
        sent++;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) rest($urandom_range(1, 6));
      end
      // now and then the sender holds off until the block has answered everything
      if (sent < CALM_TAIL_AT && (!drained_once || $urandom_range(0, 5) == 0)) begin
        drained_once = 1'b1;
        start <= 1'b0;
        do @(posedge clk); while (rsp_due.size() != 0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (rsp_due.size() != 0);
    repeat (6) @(posedge clk);
    if (rsp_due.size() != 0) note_fail("results never arrived", rsp_due[0], '0);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[k_stacks_shared_pool.f]
src/kssp_pkg.sv
src/kssp_slot_mem.sv
src/k_stacks_shared_pool.sv
tb/tb_top.sv
